>>> rtl/qvr_pkg.sv
// ----------------------------------------------------------------------------
// qvr_pkg
// Widths, word types and limits shared by the quaternion vector rotate unit.
// ----------------------------------------------------------------------------
package qvr_pkg;

    localparam int COMP_WIDTH = 16;
    localparam int QUAT_FRAC  = COMP_WIDTH - 2;
    localparam int RSHIFT     = 2 * QUAT_FRAC;
    localparam int PROD_W     = 2 * COMP_WIDTH;
    localparam int MAT_W      = PROD_W + 2;
    localparam int DOT_W      = MAT_W + COMP_WIDTH;
    localparam int SUM_W      = DOT_W + 2;
    localparam int SHR_W      = SUM_W - RSHIFT;

    typedef logic signed [COMP_WIDTH-1:0] comp_t;
    typedef logic signed [MAT_W-1:0]      mat_t;

    localparam comp_t COMP_MAX = {1'b0, {(COMP_WIDTH-1){1'b1}}};
    localparam comp_t COMP_MIN = {1'b1, {(COMP_WIDTH-1){1'b0}}};

    typedef struct packed {
        comp_t vec_x;
        comp_t vec_y;
        comp_t vec_z;
        comp_t quat_w;
        comp_t quat_x;
        comp_t quat_y;
        comp_t quat_z;
    } cmd_word_t;

    typedef struct packed {
        comp_t rot_x;
        comp_t rot_y;
        comp_t rot_z;
        logic  saturated;
    } res_word_t;

    typedef struct packed {
        mat_t  m00;
        mat_t  m01;
        mat_t  m02;
        mat_t  m10;
        mat_t  m11;
        mat_t  m12;
        mat_t  m20;
        mat_t  m21;
        mat_t  m22;
        comp_t vec_x;
        comp_t vec_y;
        comp_t vec_z;
    } mat_word_t;

endpackage

>>> rtl/qvr_mat.sv
// ----------------------------------------------------------------------------
// qvr_mat
// Two pipeline stages: quaternion products, then the nine matrix entries.
// ----------------------------------------------------------------------------
module qvr_mat
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  qvr_pkg::cmd_word_t  cmd_word,
    output logic                mat_valid,
    input  logic                mat_stall,
    output qvr_pkg::mat_word_t  mat_word
);

    typedef logic signed [qvr_pkg::PROD_W-1:0] prod_t;

    typedef struct packed {
        prod_t          ww;
        prod_t          xx;
        prod_t          yy;
        prod_t          zz;
        prod_t          xy;
        prod_t          xz;
        prod_t          yz;
        prod_t          wx;
        prod_t          wy;
        prod_t          wz;
        qvr_pkg::comp_t vec_x;
        qvr_pkg::comp_t vec_y;
        qvr_pkg::comp_t vec_z;
    } prod_word_t;

    logic               prod_valid_reg;
    logic               prod_stall;
    prod_word_t         prod_reg;
    prod_word_t         prod_next;
    logic               mat_valid_reg;
    logic               mat_hold;
    qvr_pkg::mat_word_t mat_reg;
    qvr_pkg::mat_word_t mat_next;
    qvr_pkg::mat_t      t01;
    qvr_pkg::mat_t      t02;
    qvr_pkg::mat_t      t10;
    qvr_pkg::mat_t      t12;
    qvr_pkg::mat_t      t20;
    qvr_pkg::mat_t      t21;

    assign mat_hold   = mat_valid_reg && mat_stall;
    assign prod_stall = prod_valid_reg && mat_hold;
    assign cmd_stall  = prod_stall;

    always_comb
    begin
        prod_next.ww    = prod_t'(cmd_word.quat_w) * prod_t'(cmd_word.quat_w);
        prod_next.xx    = prod_t'(cmd_word.quat_x) * prod_t'(cmd_word.quat_x);
        prod_next.yy    = prod_t'(cmd_word.quat_y) * prod_t'(cmd_word.quat_y);
        prod_next.zz    = prod_t'(cmd_word.quat_z) * prod_t'(cmd_word.quat_z);
        prod_next.xy    = prod_t'(cmd_word.quat_x) * prod_t'(cmd_word.quat_y);
        prod_next.xz    = prod_t'(cmd_word.quat_x) * prod_t'(cmd_word.quat_z);
        prod_next.yz    = prod_t'(cmd_word.quat_y) * prod_t'(cmd_word.quat_z);
        prod_next.wx    = prod_t'(cmd_word.quat_w) * prod_t'(cmd_word.quat_x);
        prod_next.wy    = prod_t'(cmd_word.quat_w) * prod_t'(cmd_word.quat_y);
        prod_next.wz    = prod_t'(cmd_word.quat_w) * prod_t'(cmd_word.quat_z);
        prod_next.vec_x = cmd_word.vec_x;
        prod_next.vec_y = cmd_word.vec_y;
        prod_next.vec_z = cmd_word.vec_z;
    end

    always_comb
    begin
        t01 = qvr_pkg::mat_t'(prod_reg.xy) - qvr_pkg::mat_t'(prod_reg.wz);
        t02 = qvr_pkg::mat_t'(prod_reg.xz) + qvr_pkg::mat_t'(prod_reg.wy);
        t10 = qvr_pkg::mat_t'(prod_reg.xy) + qvr_pkg::mat_t'(prod_reg.wz);
        t12 = qvr_pkg::mat_t'(prod_reg.yz) - qvr_pkg::mat_t'(prod_reg.wx);
        t20 = qvr_pkg::mat_t'(prod_reg.xz) - qvr_pkg::mat_t'(prod_reg.wy);
        t21 = qvr_pkg::mat_t'(prod_reg.wx) + qvr_pkg::mat_t'(prod_reg.yz);

        mat_next.m00 = qvr_pkg::mat_t'(prod_reg.ww) + qvr_pkg::mat_t'(prod_reg.xx)
                     - qvr_pkg::mat_t'(prod_reg.yy) - qvr_pkg::mat_t'(prod_reg.zz);
        mat_next.m11 = qvr_pkg::mat_t'(prod_reg.ww) - qvr_pkg::mat_t'(prod_reg.xx)
                     + qvr_pkg::mat_t'(prod_reg.yy) - qvr_pkg::mat_t'(prod_reg.zz);
        mat_next.m22 = qvr_pkg::mat_t'(prod_reg.ww) - qvr_pkg::mat_t'(prod_reg.xx)
                     - qvr_pkg::mat_t'(prod_reg.yy) + qvr_pkg::mat_t'(prod_reg.zz);
        mat_next.m01 = t01 + t01;
        mat_next.m02 = t02 + t02;
        mat_next.m10 = t10 + t10;
        mat_next.m12 = t12 + t12;
        mat_next.m20 = t20 + t20;
        mat_next.m21 = t21 + t21;
        mat_next.vec_x = prod_reg.vec_x;
        mat_next.vec_y = prod_reg.vec_y;
        mat_next.vec_z = prod_reg.vec_z;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            mat_valid_reg  <= 1'b0;
        end
        else
        begin
            if (!prod_stall)
            begin
                prod_valid_reg <= cmd_valid;
            end
            if (!mat_hold)
            begin
                mat_valid_reg <= prod_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!prod_stall)
        begin
            prod_reg <= prod_next;
        end
        if (!mat_hold)
        begin
            mat_reg <= mat_next;
        end
    end

    assign mat_valid = mat_valid_reg;
    assign mat_word  = mat_reg;

endmodule

>>> rtl/qvr_dot.sv
// ----------------------------------------------------------------------------
// qvr_dot
// Three pipeline stages: matrix times vector, row sums with rounding, then
// shift and saturate into the result register.
// ----------------------------------------------------------------------------
module qvr_dot
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                mat_valid,
    output logic                mat_stall,
    input  qvr_pkg::mat_word_t  mat_word,
    output logic                res_valid,
    input  logic                res_stall,
    output qvr_pkg::res_word_t  res_word
);

    typedef logic signed [qvr_pkg::DOT_W-1:0] dot_t;
    typedef logic signed [qvr_pkg::SUM_W-1:0] sum_t;
    typedef logic signed [qvr_pkg::SHR_W-1:0] shr_t;

    typedef struct packed {
        qvr_pkg::comp_t value;
        logic           flag;
    } clip_t;

    localparam sum_t ROUND_K = sum_t'(1) <<< (qvr_pkg::RSHIFT - 1);

    function automatic clip_t clip(input sum_t s);
        shr_t  q;
        clip_t r;
        q      = shr_t'(s >>> qvr_pkg::RSHIFT);
        r.flag = (q[qvr_pkg::SHR_W-1:qvr_pkg::COMP_WIDTH-1] != '0)
              && (q[qvr_pkg::SHR_W-1:qvr_pkg::COMP_WIDTH-1] != '1);
        if (r.flag)
        begin
            r.value = q[qvr_pkg::SHR_W-1] ? qvr_pkg::COMP_MIN : qvr_pkg::COMP_MAX;
        end
        else
        begin
            r.value = q[qvr_pkg::COMP_WIDTH-1:0];
        end
        return r;
    endfunction

    logic               mul_valid_reg;
    logic               mul_stall;
    dot_t [8:0]         mul_reg;
    dot_t [8:0]         mul_next;
    logic               sum_valid_reg;
    logic               sum_stall;
    sum_t [2:0]         sum_reg;
    sum_t [2:0]         sum_next;
    logic               res_valid_reg;
    logic               res_hold;
    qvr_pkg::res_word_t res_reg;
    qvr_pkg::res_word_t res_next;
    clip_t              clip_x;
    clip_t              clip_y;
    clip_t              clip_z;

    assign res_hold  = res_valid_reg && res_stall;
    assign sum_stall = sum_valid_reg && res_hold;
    assign mul_stall = mul_valid_reg && sum_stall;
    assign mat_stall = mul_stall;

    always_comb
    begin
        mul_next[0] = dot_t'(mat_word.m00) * dot_t'(mat_word.vec_x);
        mul_next[1] = dot_t'(mat_word.m01) * dot_t'(mat_word.vec_y);
        mul_next[2] = dot_t'(mat_word.m02) * dot_t'(mat_word.vec_z);
        mul_next[3] = dot_t'(mat_word.m10) * dot_t'(mat_word.vec_x);
        mul_next[4] = dot_t'(mat_word.m11) * dot_t'(mat_word.vec_y);
        mul_next[5] = dot_t'(mat_word.m12) * dot_t'(mat_word.vec_z);
        mul_next[6] = dot_t'(mat_word.m20) * dot_t'(mat_word.vec_x);
        mul_next[7] = dot_t'(mat_word.m21) * dot_t'(mat_word.vec_y);
        mul_next[8] = dot_t'(mat_word.m22) * dot_t'(mat_word.vec_z);
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sum_next[i] = sum_t'(mul_reg[3*i]) + sum_t'(mul_reg[3*i+1])
                        + sum_t'(mul_reg[3*i+2]) + ROUND_K;
        end
    end

    always_comb
    begin
        clip_x             = clip(sum_reg[0]);
        clip_y             = clip(sum_reg[1]);
        clip_z             = clip(sum_reg[2]);
        res_next.rot_x     = clip_x.value;
        res_next.rot_y     = clip_y.value;
        res_next.rot_z     = clip_z.value;
        res_next.saturated = clip_x.flag || clip_y.flag || clip_z.flag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            sum_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (!mul_stall)
            begin
                mul_valid_reg <= mat_valid;
            end
            if (!sum_stall)
            begin
                sum_valid_reg <= mul_valid_reg;
            end
            if (!res_hold)
            begin
                res_valid_reg <= sum_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!mul_stall)
        begin
            mul_reg <= mul_next;
        end
        if (!sum_stall)
        begin
            sum_reg <= sum_next;
        end
        if (!res_hold)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_word  = res_reg;

endmodule

>>> rtl/quaternion_vector_rotate_unit.sv
// ----------------------------------------------------------------------------
// quaternion_vector_rotate_unit
// Rotates a Q8.8 vector by an unnormalized Q2.14 quaternion, with rounding
// and saturation of each result component.
//
//   channel   handshake             word
//   cmd       cmd_valid/cmd_stall   vector and quaternion (cmd_word_t)
//   res       res_valid/res_stall   rotated vector, saturated (res_word_t)
//
// Five register stages: products, matrix, matrix times vector, row sums,
// saturate. One word in and one word out each cycle while res is not stalled.
// Reset clears only the stage valid bits.
// A stall on res holds the run of full stages next to the output; a stage
// behind an empty one keeps advancing, so cmd_stall rises only when all five
// stages are full and res is stalled.
// ----------------------------------------------------------------------------
module quaternion_vector_rotate_unit
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  qvr_pkg::cmd_word_t  cmd_word,
    output logic                res_valid,
    input  logic                res_stall,
    output qvr_pkg::res_word_t  res_word
);

    logic               mat_valid;
    logic               mat_stall;
    qvr_pkg::mat_word_t mat_word;

    qvr_mat u_mat
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_word  (cmd_word),
        .mat_valid (mat_valid),
        .mat_stall (mat_stall),
        .mat_word  (mat_word)
    );

    qvr_dot u_dot
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .mat_valid (mat_valid),
        .mat_stall (mat_stall),
        .mat_word  (mat_word),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_word  (res_word)
    );

    a_cmd_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> (res_valid && res_stall && mat_valid))
        else $error("cmd stall without a blocked result");

    a_mat_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        mat_stall |-> (res_valid && res_stall))
        else $error("matrix stage stalled without a blocked result");

    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_word.saturated) |->
            (res_word.rot_x == qvr_pkg::COMP_MAX || res_word.rot_x == qvr_pkg::COMP_MIN
          || res_word.rot_y == qvr_pkg::COMP_MAX || res_word.rot_y == qvr_pkg::COMP_MIN
          || res_word.rot_z == qvr_pkg::COMP_MAX || res_word.rot_z == qvr_pkg::COMP_MIN))
        else $error("saturated flag without a clamped component");

endmodule
